@@ rtl/mws_pkg.sv @@
// Shared constants, widths and types for the minimum window subsequence block.
// No dependencies; used by mws_cell, mws_search and min_window_subsequence.
package mws_pkg;

    localparam int MAX_TEXT     = 1024;
    localparam int MAX_PATTERN  = 256;
    localparam int SYMBOL_WIDTH = 16;

    // Fixed field widths of the block's ports
    localparam int SYM_PORT_W  = 16;
    localparam int TEXT_LEN_W  = 11;
    localparam int PAT_LEN_W   = 9;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 11;
    localparam int WIN_W       = 11;

    // Derived internal widths
    localparam int TEXT_AW = (MAX_TEXT > 1) ? $clog2(MAX_TEXT) : 1;
    localparam int PAT_AW  = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int LEN_W   = $clog2(MAX_TEXT + 2);      // holds infinity n+1
    localparam int PCNT_W  = $clog2(MAX_PATTERN + 1);

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TEXT_LEN    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LEN = 2'd1;

    // Action codes
    localparam logic ACT_TEXT    = 1'b0;
    localparam logic ACT_PATTERN = 1'b1;

    typedef struct packed {
        logic              start;
        logic [LEN_W-1:0]  n;
        logic [PCNT_W-1:0] m;
    } t_search_req;

endpackage

@@ rtl/mws_ram.sv @@
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module mws_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

@@ rtl/mws_cell.sv @@
// Shared compare / saturating-increment unit, used once per DP step and per
// minimum-scan step. Depends on mws_pkg.
module mws_cell (
    input  logic [mws_pkg::SYMBOL_WIDTH-1:0] i_text_sym,
    input  logic [mws_pkg::SYMBOL_WIDTH-1:0] i_pat_sym,
    input  logic [mws_pkg::LEN_W-1:0]        i_old_next,
    input  logic [mws_pkg::LEN_W-1:0]        i_new_next,
    input  logic [mws_pkg::LEN_W-1:0]        i_inf,
    input  logic [mws_pkg::LEN_W-1:0]        i_cmp_a,
    input  logic [mws_pkg::LEN_W-1:0]        i_cmp_b,
    output logic [mws_pkg::LEN_W-1:0]        o_value,
    output logic                             o_less
);

    logic [mws_pkg::LEN_W-1:0] sel;

    always_comb begin
        sel     = (i_text_sym == i_pat_sym) ? i_old_next : i_new_next;
        o_value = (sel >= i_inf) ? i_inf : sel + 1'b1;
        o_less  = (i_cmp_a < i_cmp_b);
    end

endmodule

@@ rtl/mws_search.sv @@
// Search sequencer: one DP row per pattern symbol (last to first), then a
// minimum scan over the row, then the result register. Depends on mws_pkg,
// mws_cell.
module mws_search (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  mws_pkg::t_search_req             i_req,
    output logic                             o_busy,
    output logic [mws_pkg::TEXT_AW-1:0]      o_raddr,
    input  logic [mws_pkg::SYMBOL_WIDTH-1:0] i_text_rdata,
    input  logic [mws_pkg::LEN_W-1:0]        i_dp_rdata,
    output logic [mws_pkg::PAT_AW-1:0]       o_pat_raddr,
    input  logic [mws_pkg::SYMBOL_WIDTH-1:0] i_pat_rdata,
    output logic                             o_dp_we,
    output logic [mws_pkg::TEXT_AW-1:0]      o_dp_waddr,
    output logic [mws_pkg::LEN_W-1:0]        o_dp_wdata,
    input  logic                             i_stall,
    output logic                             o_valid,
    output logic                             o_found,
    output logic [mws_pkg::WIN_W-1:0]        o_window_length,
    output logic [mws_pkg::WIN_W-1:0]        o_window_start
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ROW,
        S_SCAN,
        S_MIN0,
        S_MIN,
        S_DONE
    } t_state;

    t_state                        r_state;
    logic [mws_pkg::PAT_AW-1:0]    r_i;
    logic [mws_pkg::TEXT_AW-1:0]   r_j;
    logic                          r_first;
    logic [mws_pkg::LEN_W-1:0]     r_old;
    logic [mws_pkg::LEN_W-1:0]     r_new;
    logic [mws_pkg::LEN_W-1:0]     r_best;
    logic [mws_pkg::TEXT_AW-1:0]   r_best_idx;
    logic [mws_pkg::LEN_W-1:0]     r_n;
    logic                          r_out_valid;
    logic                          r_found;
    logic [mws_pkg::WIN_W-1:0]     r_len;
    logic [mws_pkg::WIN_W-1:0]     r_start;

    logic [mws_pkg::LEN_W-1:0]     inf;
    logic [mws_pkg::LEN_W-1:0]     n_minus1;
    logic [mws_pkg::LEN_W-1:0]     cell_value;
    logic                          cell_less;
    logic                          out_free;
    logic                          best_found;

    assign inf      = r_n + 1'b1;
    assign n_minus1 = r_n - 1'b1;
    assign out_free = !r_out_valid || !i_stall;
    assign best_found = (r_best <= r_n);

    mws_cell u_cell (
        .i_text_sym (i_text_rdata),
        .i_pat_sym  (i_pat_rdata),
        .i_old_next (r_old),
        .i_new_next (r_new),
        .i_inf      (inf),
        .i_cmp_a    (i_dp_rdata),
        .i_cmp_b    (r_best),
        .o_value    (cell_value),
        .o_less     (cell_less)
    );

    // Read address is the value r_j takes in the next cycle; the RAM output belongs to r_j.
    always_comb begin
        unique case (r_state)
            S_ROW:   o_raddr = n_minus1[mws_pkg::TEXT_AW-1:0];
            S_SCAN:  o_raddr = r_j - 1'b1;
            S_MIN0:  o_raddr = '0;
            S_MIN:   o_raddr = r_j + 1'b1;
            default: o_raddr = r_j;
        endcase
    end

    assign o_pat_raddr = r_i;
    assign o_dp_we     = (r_state == S_SCAN);
    assign o_dp_waddr  = r_j;
    assign o_dp_wdata  = cell_value;
    assign o_busy      = (r_state != S_IDLE);

    assign o_valid         = r_out_valid;
    assign o_found         = r_found;
    assign o_window_length = r_len;
    assign o_window_start  = r_start;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_req.start) begin
                        r_n     <= i_req.n;
                        r_i     <= mws_pkg::PAT_AW'(i_req.m - 1'b1);
                        r_first <= 1'b1;
                        r_state <= S_ROW;
                    end
                end
                S_ROW: begin
                    r_j     <= n_minus1[mws_pkg::TEXT_AW-1:0];
                    r_old   <= r_first ? '0 : inf;
                    r_new   <= inf;
                    r_state <= S_SCAN;
                end
                S_SCAN: begin
                    r_new <= cell_value;
                    r_old <= r_first ? '0 : i_dp_rdata;
                    if (r_j == '0) begin
                        if (r_i == '0) begin
                            r_state <= S_MIN0;
                        end else begin
                            r_i     <= r_i - 1'b1;
                            r_first <= 1'b0;
                            r_state <= S_ROW;
                        end
                    end else begin
                        r_j <= r_j - 1'b1;
                    end
                end
                S_MIN0: begin
                    r_j     <= '0;
                    r_state <= S_MIN;
                end
                S_MIN: begin
                    // strict less keeps the earliest start on ties
                    if (r_j == '0 || cell_less) begin
                        r_best     <= i_dp_rdata;
                        r_best_idx <= r_j;
                    end
                    if (mws_pkg::LEN_W'(r_j) == n_minus1) begin
                        r_state <= S_DONE;
                    end else begin
                        r_j <= r_j + 1'b1;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_found     <= best_found;
                        r_len       <= best_found ? mws_pkg::WIN_W'(r_best)
                                                  : mws_pkg::WIN_W'(inf);
                        r_start     <= best_found
                                       ? mws_pkg::WIN_W'(mws_pkg::LEN_W'(r_best_idx) + 1'b1)
                                       : mws_pkg::WIN_W'(1);
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |-> r_state == S_IDLE)
        else $error("search request while busy");

    a_start_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.start && r_state == S_IDLE) |=> r_state == S_ROW)
        else $error("search request not taken");

    a_scan_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN || r_state == S_MIN) |-> mws_pkg::LEN_W'(r_j) < r_n)
        else $error("scan index beyond text length");

    a_best_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DONE |-> r_best <= inf)
        else $error("window length above infinity");

    a_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && out_free) |=>
            (r_out_valid && (r_found ? (r_len != '0) : (r_start == mws_pkg::WIN_W'(1)))))
        else $error("inconsistent result");

endmodule

@@ rtl/min_window_subsequence.sv @@
// Minimum window subsequence search: text/pattern loading, config registers,
// symbol and DP memories. Depends on mws_pkg, mws_ram, mws_search.
// Load items: accepted one per cycle while idle; a text item causes no result.
// Final pattern item: o_stall rises the next cycle and stays high through one DP row
// per pattern symbol (through the shared cell unit and the DP row RAM), then a minimum
// scan over the row, until the result register loads (held off while an earlier
// result is stalled). Reset (sync, active low) sets text_len and pattern_len to 1,
// clears counters and result valid; the RAMs are not cleared.
module min_window_subsequence (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic                               i_action,
    input  logic [mws_pkg::SYM_PORT_W-1:0]     i_symbol,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic                               o_found,
    output logic [mws_pkg::WIN_W-1:0]          o_window_length,
    output logic [mws_pkg::WIN_W-1:0]          o_window_start,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [mws_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [mws_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    logic [mws_pkg::TEXT_LEN_W-1:0] r_text_len;
    logic [mws_pkg::PAT_LEN_W-1:0]  r_pat_len;
    logic [mws_pkg::LEN_W-1:0]      r_text_count;
    logic [mws_pkg::PCNT_W-1:0]     r_pat_count;

    logic [mws_pkg::LEN_W-1:0]      n_len;
    logic [mws_pkg::PCNT_W-1:0]     m_len;
    logic [mws_pkg::PCNT_W-1:0]     n_pat_count;
    logic                           busy;
    logic                           accept;
    logic                           text_we;
    logic                           pat_we;
    logic                           trigger;
    mws_pkg::t_search_req           req;

    logic [mws_pkg::TEXT_AW-1:0]      raddr;
    logic [mws_pkg::SYMBOL_WIDTH-1:0] text_rdata;
    logic [mws_pkg::PAT_AW-1:0]       pat_raddr;
    logic [mws_pkg::SYMBOL_WIDTH-1:0] pat_rdata;
    logic                             dp_we;
    logic [mws_pkg::TEXT_AW-1:0]      dp_waddr;
    logic [mws_pkg::LEN_W-1:0]        dp_wdata;
    logic [mws_pkg::LEN_W-1:0]        dp_rdata;

    // lengths clamped to 1..max
    always_comb begin
        if (r_text_len == '0) begin
            n_len = mws_pkg::LEN_W'(1);
        end else if (r_text_len > mws_pkg::TEXT_LEN_W'(mws_pkg::MAX_TEXT)) begin
            n_len = mws_pkg::LEN_W'(mws_pkg::MAX_TEXT);
        end else begin
            n_len = mws_pkg::LEN_W'(r_text_len);
        end
        if (r_pat_len == '0) begin
            m_len = mws_pkg::PCNT_W'(1);
        end else if (r_pat_len > mws_pkg::PAT_LEN_W'(mws_pkg::MAX_PATTERN)) begin
            m_len = mws_pkg::PCNT_W'(mws_pkg::MAX_PATTERN);
        end else begin
            m_len = mws_pkg::PCNT_W'(r_pat_len);
        end
    end

    assign o_stall     = busy;
    assign o_cfg_ready = 1'b1;
    assign accept      = i_valid && !busy;
    assign n_pat_count = r_pat_count + 1'b1;
    assign text_we     = accept && (i_action == mws_pkg::ACT_TEXT) && (r_text_count < n_len);
    assign pat_we      = accept && (i_action == mws_pkg::ACT_PATTERN)
                         && (r_pat_count < mws_pkg::PCNT_W'(mws_pkg::MAX_PATTERN));
    assign trigger     = accept && (i_action == mws_pkg::ACT_PATTERN) && (n_pat_count >= m_len);

    assign req.start = trigger;
    assign req.n     = n_len;
    assign req.m     = m_len;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_text_len   <= mws_pkg::TEXT_LEN_W'(1);
            r_pat_len    <= mws_pkg::PAT_LEN_W'(1);
            r_text_count <= '0;
            r_pat_count  <= '0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    mws_pkg::CFG_TEXT_LEN:    r_text_len <= i_cfg_data[mws_pkg::TEXT_LEN_W-1:0];
                    mws_pkg::CFG_PATTERN_LEN: r_pat_len  <= i_cfg_data[mws_pkg::PAT_LEN_W-1:0];
                    default: ;
                endcase
            end
            if (trigger) begin
                r_text_count <= '0;
                r_pat_count  <= '0;
            end else begin
                if (text_we) begin
                    r_text_count <= r_text_count + 1'b1;
                end
                if (accept && (i_action == mws_pkg::ACT_PATTERN)) begin
                    r_pat_count <= n_pat_count;
                end
            end
        end
    end

    mws_ram #(.WIDTH(mws_pkg::SYMBOL_WIDTH), .DEPTH(mws_pkg::MAX_TEXT)) u_text_ram (
        .i_clk   (i_clk),
        .i_we    (text_we),
        .i_waddr (r_text_count[mws_pkg::TEXT_AW-1:0]),
        .i_wdata (i_symbol[mws_pkg::SYMBOL_WIDTH-1:0]),
        .i_raddr (raddr),
        .o_rdata (text_rdata)
    );

    mws_ram #(.WIDTH(mws_pkg::SYMBOL_WIDTH), .DEPTH(mws_pkg::MAX_PATTERN)) u_pat_ram (
        .i_clk   (i_clk),
        .i_we    (pat_we),
        .i_waddr (r_pat_count[mws_pkg::PAT_AW-1:0]),
        .i_wdata (i_symbol[mws_pkg::SYMBOL_WIDTH-1:0]),
        .i_raddr (pat_raddr),
        .o_rdata (pat_rdata)
    );

    mws_ram #(.WIDTH(mws_pkg::LEN_W), .DEPTH(mws_pkg::MAX_TEXT)) u_dp_ram (
        .i_clk   (i_clk),
        .i_we    (dp_we),
        .i_waddr (dp_waddr),
        .i_wdata (dp_wdata),
        .i_raddr (raddr),
        .o_rdata (dp_rdata)
    );

    mws_search u_search (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_req           (req),
        .o_busy          (busy),
        .o_raddr         (raddr),
        .i_text_rdata    (text_rdata),
        .i_dp_rdata      (dp_rdata),
        .o_pat_raddr     (pat_raddr),
        .i_pat_rdata     (pat_rdata),
        .o_dp_we         (dp_we),
        .o_dp_waddr      (dp_waddr),
        .o_dp_wdata      (dp_wdata),
        .i_stall         (i_stall),
        .o_valid         (o_valid),
        .o_found         (o_found),
        .o_window_length (o_window_length),
        .o_window_start  (o_window_start)
    );

endmodule

@@ test/tb.sv @@
// Self-checking testbench for min_window_subsequence: directed table, extreme sizes,
// then random load/search requests checked against a built-in window predictor.
// Depends on rtl/mws_pkg.sv and rtl/min_window_subsequence.sv.
`timescale 1ns / 1ps

module tb;
    import mws_pkg::*;

    localparam int          LIMIT         = 1_000_000;
    localparam int          RAND_ITEMS    = 900;
    localparam int          MIN_RESULTS   = 48;
    localparam int          IDLE_SETTLE   = 8;
    localparam int          DRAIN         = 64;
    localparam int          REPORT_MAX    = 10;
    localparam logic [1:0]  CFG_SPARE_LO  = 2'd2;
    localparam logic [1:0]  CFG_SPARE_HI  = 2'd3;

    typedef struct packed {
        logic              found;
        logic [WIN_W-1:0]  length;
        logic [WIN_W-1:0]  start;
    } window_t;

    typedef enum logic [1:0] {ROW_CFG, ROW_TEXT, ROW_PAT} row_kind_t;

    typedef struct {
        row_kind_t    kind;
        logic [1:0]   index;
        logic [15:0]  value;
        bit           typed;
        window_t      want;
    } plan_row_t;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   i_valid;
    logic                   o_stall;
    logic                   i_action;
    logic [SYM_PORT_W-1:0]  i_symbol;
    logic                   o_valid;
    logic                   i_stall;
    logic                   o_found;
    logic [WIN_W-1:0]       o_window_length;
    logic [WIN_W-1:0]       o_window_start;
    logic                   i_cfg_valid;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index;
    logic [CFG_DATA_W-1:0]  i_cfg_data;

    min_window_subsequence dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_action        (i_action),
        .i_symbol        (i_symbol),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_found         (o_found),
        .o_window_length (o_window_length),
        .o_window_start  (o_window_start),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    // predictor state
    logic [15:0]        text_mem [0:MAX_TEXT-1];
    logic [15:0]        pat_mem  [0:MAX_PATTERN-1];
    int                 span     [0:MAX_TEXT-1];
    logic [TEXT_LEN_W-1:0] text_len_reg = 1;
    logic [PAT_LEN_W-1:0]  pat_len_reg  = 1;
    int                 text_cnt = 0;
    int                 pat_cnt  = 0;
    int                 text_hwm = 0;   // positions ever loaded

    window_t            expected_q [$];
    plan_row_t          plan [$];
    int                 taken_items  = 0;
    int                 results_due  = 0;
    int                 mismatches   = 0;
    bit                 tx_quiet     = 1'b0;
    bit                 rx_quiet     = 1'b0;
    bit                 rx_armed     = 1'b0;
    int                 rx_left      = 0;
    window_t            got;
    window_t            want_now;

    function automatic int eff_len(input int v, input int cap);
        return (v < 1) ? 1 : ((v > cap) ? cap : v);
    endfunction

    // one-row DP, pattern walked from its last symbol to its first
    function automatic window_t search_window();
        int          n, m, inf, best, best_at, old_next, new_next, cur_old, v;
        bit          last_sym;
        logic [15:0] p;
        window_t     r;
        n = eff_len(text_len_reg, MAX_TEXT);
        m = eff_len(pat_len_reg, MAX_PATTERN);
        inf = n + 1;
        for (int i = m - 1; i >= 0; i--) begin
            last_sym = (i == m - 1);
            old_next = last_sym ? 0 : inf;
            new_next = inf;
            p = pat_mem[i];
            for (int j = n - 1; j >= 0; j--) begin
                cur_old = span[j];
                if (text_mem[j] == p)
                    v = (old_next >= inf) ? inf : old_next + 1;
                else
                    v = (new_next >= inf) ? inf : new_next + 1;
                span[j] = v;
                old_next = last_sym ? 0 : cur_old;
                new_next = v;
            end
        end
        best = span[0];
        best_at = 0;
        for (int j = 1; j < n; j++) begin
            if (span[j] < best) begin
                best = span[j];
                best_at = j;
            end
        end
        r.found  = (best <= n);
        r.length = r.found ? best : inf;
        r.start  = r.found ? best_at + 1 : 1;
        return r;
    endfunction

    function automatic bit window_step(input logic act, input logic [15:0] sym,
                                       output window_t res);
        int n, m;
        res = '0;
        if (act == ACT_TEXT) begin
            n = eff_len(text_len_reg, MAX_TEXT);
            if (text_cnt < n) begin
                text_mem[text_cnt] = sym;
                text_cnt++;
                if (text_cnt > text_hwm)
                    text_hwm = text_cnt;
                taken_items++;
            end
            return 1'b0;
        end
        taken_items++;
        m = eff_len(pat_len_reg, MAX_PATTERN);
        if (pat_cnt < MAX_PATTERN)
            pat_mem[pat_cnt] = sym;
        pat_cnt++;
        if (pat_cnt >= m) begin
            res = search_window();
            text_cnt = 0;
            pat_cnt = 0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic plan_row_t plan_row(input row_kind_t kind, input logic [1:0] index,
                                           input logic [15:0] value, input bit typed,
                                           input logic f, input int len, input int st);
        plan_row_t r;
        r.kind = kind;
        r.index = index;
        r.value = value;
        r.typed = typed;
        r.want.found = f;
        r.want.length = len;
        r.want.start = st;
        return r;
    endfunction

    task automatic send_symbol(input logic act, input logic [15:0] sym,
                               input bit typed, input window_t want);
        window_t r;
        int      gap;
        gap = tx_quiet ? 0 : $urandom_range(0, 7);
        @(negedge i_clk);
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid  <= 1'b1;
        i_action <= act;
        i_symbol <= sym;
        do @(posedge i_clk); while (o_stall);
        if (window_step(act, sym, r)) begin
            expected_q.push_back(typed ? want : r);
            results_due++;
        end
    endtask

    // drop the request line and let every pending search finish
    task automatic wait_idle();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (IDLE_SETTLE) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == CFG_TEXT_LEN)
            text_len_reg = data;
        else if (idx == CFG_PATTERN_LEN)
            pat_len_reg = data[PAT_LEN_W-1:0];
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic run_phase();
        int          n, m, want_text, want_pat, asize, pick, mode, r;
        logic [15:0] alpha [4];
        window_t     none;
        none = '0;
        tx_quiet = ($urandom_range(0, 3) == 0);
        rx_quiet = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 1) == 1) begin
            wait_idle();
            r = $urandom_range(0, 15);
            cfg_write(CFG_TEXT_LEN, (r == 0) ? 0 :
                      (r == 1) ? $urandom_range(17, 64) : $urandom_range(1, 12));
            r = $urandom_range(0, 19);
            cfg_write(CFG_PATTERN_LEN, (r == 0) ? $urandom_range(0, 2047) :
                      (r == 1) ? 0 :
                      (r <= 4) ? $urandom_range(7, 12) : $urandom_range(1, 6));
            if ($urandom_range(0, 7) == 0)
                cfg_write($urandom_range(0, 1) ? CFG_SPARE_LO : CFG_SPARE_HI,
                          $urandom_range(0, 2047));
        end
        n = eff_len(text_len_reg, MAX_TEXT);
        m = eff_len(pat_len_reg, MAX_PATTERN);
        asize = $urandom_range(1, 4);
        for (int i = 0; i < 4; i++)
            alpha[i] = $urandom;

        // text: full load, or a partial one reusing positions from an earlier search
        want_text = (n > text_cnt) ? n - text_cnt : 0;
        if (text_hwm >= n && $urandom_range(0, 3) == 0)
            want_text = $urandom_range(0, want_text);
        for (int i = 0; i < want_text; i++)
            send_symbol(ACT_TEXT, alpha[$urandom_range(0, asize - 1)], 1'b0, none);
        if ($urandom_range(0, 5) == 0) begin
            r = $urandom_range(1, 3);
            for (int i = 0; i < r; i++)
                send_symbol(ACT_TEXT, $urandom, 1'b0, none);
        end

        want_pat = (pat_cnt >= m) ? 1 : m - pat_cnt;
        if (want_pat > 1 && $urandom_range(0, 9) == 0)
            want_pat = $urandom_range(1, want_pat - 1);
        mode = $urandom_range(0, 9);
        pick = 0;
        for (int i = 0; i < want_pat; i++) begin
            if (mode < 6) begin
                // ordered picks from the text: mostly a real subsequence
                send_symbol(ACT_PATTERN, text_mem[pick], 1'b0, none);
                pick = pick + $urandom_range(1, 2);
                if (pick > n - 1)
                    pick = n - 1;
            end else if (mode < 9) begin
                send_symbol(ACT_PATTERN, alpha[$urandom_range(0, asize - 1)], 1'b0, none);
            end else begin
                send_symbol(ACT_PATTERN, $urandom, 1'b0, none);
            end
        end
    endtask

    // result side: a random stall per result, none in quiet phases
    initial begin
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (o_valid && !rx_armed) begin
                rx_armed = 1'b1;
                rx_left = rx_quiet ? 0 : $urandom_range(0, 7);
            end
            if (rx_left > 0) begin
                i_stall <= 1'b1;
                rx_left--;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            rx_armed = 1'b0;
            got.found  = o_found;
            got.length = o_window_length;
            got.start  = o_window_start;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("unexpected result: found=%0d len=%0d start=%0d",
                             got.found, got.length, got.start);
            end else begin
                want_now = expected_q.pop_front();
                if (got.found !== want_now.found || got.length !== want_now.length ||
                    got.start !== want_now.start) begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display("mismatch: expected found=%0d len=%0d start=%0d, got found=%0d len=%0d start=%0d",
                                 want_now.found, want_now.length, want_now.start,
                                 got.found, got.length, got.start);
                end
            end
        end
    end

    initial begin
        repeat (LIMIT) @(posedge i_clk);
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        logic [15:0] alpha [3];
        int          base;
        window_t     none;
        none = '0;
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_action    = ACT_TEXT;
        i_symbol    = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_TEXT_LEN;
        i_cfg_data  = '0;

        // registers at reset: one text position, one pattern symbol
        plan.push_back(plan_row(ROW_TEXT, 0, 16'h0000, 0, 0, 0, 0));
        plan.push_back(plan_row(ROW_PAT,  0, 16'h0000, 1, 1, 1, 1));
        plan.push_back(plan_row(ROW_TEXT, 0, 16'hFFFF, 0, 0, 0, 0));
        plan.push_back(plan_row(ROW_PAT,  0, 16'h0000, 1, 0, 2, 1));
        // second text item is past text_len and dropped
        plan.push_back(plan_row(ROW_TEXT, 0, 16'hAAAA, 0, 0, 0, 0));
        plan.push_back(plan_row(ROW_TEXT, 0, 16'h5555, 0, 0, 0, 0));
        plan.push_back(plan_row(ROW_PAT,  0, 16'hAAAA, 1, 1, 1, 1));
        // no text loaded: search sees the old symbol
        plan.push_back(plan_row(ROW_PAT,  0, 16'h5555, 1, 0, 2, 1));
        plan.push_back(plan_row(ROW_CFG,  CFG_TEXT_LEN,    0, 0, 0, 0, 0));
        plan.push_back(plan_row(ROW_CFG,  CFG_PATTERN_LEN, 0, 0, 0, 0, 0));
        plan.push_back(plan_row(ROW_TEXT, 0, 16'h8001, 0, 0, 0, 0));
        plan.push_back(plan_row(ROW_PAT,  0, 16'h8001, 1, 1, 1, 1));
        plan.push_back(plan_row(ROW_CFG,  CFG_TEXT_LEN,    4, 0, 0, 0, 0));
        plan.push_back(plan_row(ROW_CFG,  CFG_PATTERN_LEN, 2, 0, 0, 0, 0));
        plan.push_back(plan_row(ROW_TEXT, 0, 16'h0005, 0, 0, 0, 0));
        plan.push_back(plan_row(ROW_TEXT, 0, 16'h0006, 0, 0, 0, 0));
        plan.push_back(plan_row(ROW_TEXT, 0, 16'h0005, 0, 0, 0, 0));
        plan.push_back(plan_row(ROW_TEXT, 0, 16'h0006, 0, 0, 0, 0));
        // two equal windows: earliest start wins
        plan.push_back(plan_row(ROW_PAT,  0, 16'h0005, 0, 0, 0, 0));
        plan.push_back(plan_row(ROW_PAT,  0, 16'h0006, 1, 1, 2, 1));
        // pattern_len lowered mid-load: next pattern item triggers the search
        plan.push_back(plan_row(ROW_CFG,  CFG_PATTERN_LEN, 3, 0, 0, 0, 0));
        plan.push_back(plan_row(ROW_PAT,  0, 16'h0006, 0, 0, 0, 0));
        plan.push_back(plan_row(ROW_CFG,  CFG_PATTERN_LEN, 1, 0, 0, 0, 0));
        plan.push_back(plan_row(ROW_PAT,  0, 16'h0005, 1, 1, 1, 2));
        plan.push_back(plan_row(ROW_CFG,  CFG_SPARE_LO, 7, 0, 0, 0, 0));
        plan.push_back(plan_row(ROW_CFG,  CFG_SPARE_HI, 16'h07FF, 0, 0, 0, 0));
        plan.push_back(plan_row(ROW_CFG,  CFG_PATTERN_LEN, 2, 0, 0, 0, 0));
        plan.push_back(plan_row(ROW_TEXT, 0, 16'h0003, 0, 0, 0, 0));
        plan.push_back(plan_row(ROW_TEXT, 0, 16'h0001, 0, 0, 0, 0));
        plan.push_back(plan_row(ROW_TEXT, 0, 16'h0002, 0, 0, 0, 0));
        plan.push_back(plan_row(ROW_TEXT, 0, 16'h0003, 0, 0, 0, 0));
        plan.push_back(plan_row(ROW_PAT,  0, 16'h0003, 0, 0, 0, 0));
        plan.push_back(plan_row(ROW_PAT,  0, 16'h0002, 0, 0, 0, 0));

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan[k]) begin
            if (plan[k].kind == ROW_CFG) begin
                wait_idle();
                cfg_write(plan[k].index, plan[k].value[CFG_DATA_W-1:0]);
            end else begin
                send_symbol((plan[k].kind == ROW_PAT) ? ACT_PATTERN : ACT_TEXT,
                            plan[k].value, plan[k].typed, plan[k].want);
            end
        end

        // largest sizes: text_len above the maximum, then exactly at it
        for (int i = 0; i < 3; i++)
            alpha[i] = $urandom;
        tx_quiet = 1'b1;
        wait_idle();
        cfg_write(CFG_TEXT_LEN, 11'd2047);
        cfg_write(CFG_PATTERN_LEN, 11'd2);
        for (int i = 0; i < MAX_TEXT; i++)
            send_symbol(ACT_TEXT, alpha[$urandom_range(0, 2)], 1'b0, none);
        send_symbol(ACT_PATTERN, alpha[$urandom_range(0, 2)], 1'b0, none);
        send_symbol(ACT_PATTERN, alpha[$urandom_range(0, 2)], 1'b0, none);
        wait_idle();
        cfg_write(CFG_TEXT_LEN, MAX_TEXT);
        cfg_write(CFG_PATTERN_LEN, 11'd1);
        send_symbol(ACT_PATTERN, alpha[2], 1'b0, none);
        // longest pattern on a short text, over the maximum and at it
        wait_idle();
        cfg_write(CFG_TEXT_LEN, 11'd3);
        cfg_write(CFG_PATTERN_LEN, 11'd511);
        for (int i = 0; i < MAX_PATTERN; i++)
            send_symbol(ACT_PATTERN, alpha[$urandom_range(0, 2)], 1'b0, none);
        wait_idle();
        cfg_write(CFG_PATTERN_LEN, MAX_PATTERN);
        for (int i = 0; i < MAX_PATTERN; i++)
            send_symbol(ACT_PATTERN, alpha[$urandom_range(0, 1)], 1'b0, none);

        base = taken_items;
        results_due = 0;
        while (taken_items - base < RAND_ITEMS || results_due < MIN_RESULTS)
            run_phase();

        wait_idle();
        repeat (DRAIN) @(posedge i_clk);
        if (mismatches == 0 && expected_q.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

@@ files.f @@
rtl/mws_pkg.sv
rtl/mws_ram.sv
rtl/mws_cell.sv
rtl/mws_search.sv
rtl/min_window_subsequence.sv
test/tb.sv
